// ===== rtl/ftcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ftcs_pkg
// Shared widths, field positions and address constants for the flash
// transfer chunk splitter and its checker.
// ----------------------------------------------------------------------------
package ftcs_pkg;

  // default parameter values
  localparam int unsigned PAGE_SIZE_DEF         = 256;
  localparam int unsigned BOUNCE_BYTES_DEF      = 16;
  localparam int unsigned MAX_REQUEST_BYTES_DEF = 512;

  // fixed field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned BOFF_W   = 2;
  // wide enough to compare a byte count against a MAX_REQUEST_BYTES of up to 8191
  localparam int unsigned MAXCMP_W = 13;

  // results per request are capped
  localparam int unsigned RESULT_LIMIT = 34;
  localparam int unsigned RCNT_W       = 6;

  // buffer lies in RAM when (addr & RAM_MASK) == RAM_BASE
  localparam logic [ADDR_W-1:0] RAM_MASK = 32'hE000_0000;
  localparam logic [ADDR_W-1:0] RAM_BASE = 32'h2000_0000;

  // input tdata: flash_address, buffer_address, byte_count
  localparam int unsigned IN_FA_LSB   = 0;
  localparam int unsigned IN_BA_LSB   = 32;
  localparam int unsigned IN_CNT_LSB  = 64;
  localparam int unsigned IN_TDATA_W  = 80;

  // output tdata: chunk_flash_address, chunk_length, bounce_offset,
  // bytes_taken, chunk_buffer_address
  localparam int unsigned OUT_FA_LSB    = 0;
  localparam int unsigned OUT_LEN_LSB   = 32;
  localparam int unsigned OUT_BOFF_LSB  = 42;
  localparam int unsigned OUT_TAKEN_LSB = 44;
  localparam int unsigned OUT_BA_LSB    = 54;
  localparam int unsigned OUT_USED_W    = 86;
  localparam int unsigned OUT_TDATA_W   = 88;

endpackage

// ===== rtl/flash_transfer_chunk_splitter_top.sv =====
// ----------------------------------------------------------------------------
// flash_transfer_chunk_splitter_top
// Splits one flash read/write request into word-aligned DMA chunk
// descriptors, direct or through the bounce buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per handshake. in_tuser is func (0 read, 1 write);
//           in_tdata carries flash address, buffer address and byte count.
//   out_* : one chunk descriptor per handshake; out_tuser flags a bounce
//           chunk and out_tlast marks the final chunk of the request.
//   A request with a zero byte count produces no descriptor.
// Timing:
//   A small sequencer reuses one chunk calculator: the CALC state computes a
//   chunk into the output register, then the descriptor waits in SEND for the
//   handshake, where the addresses and remaining count advance. A request is
//   taken in IDLE and passes through CALC before its first descriptor is
//   valid in SEND.
//   in_tready is high only while no request is in progress.
// Reset: sequencer returns to idle, out_tvalid drops, in_tready rises.
// Stall: a held descriptor stays stable until out_tready; no work advances.
// ----------------------------------------------------------------------------
module flash_transfer_chunk_splitter_top #(
  parameter int unsigned PAGE_SIZE         = ftcs_pkg::PAGE_SIZE_DEF,
  parameter int unsigned BOUNCE_BYTES      = ftcs_pkg::BOUNCE_BYTES_DEF,
  parameter int unsigned MAX_REQUEST_BYTES = ftcs_pkg::MAX_REQUEST_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // flash_address[31:0], buffer_address[63:32], byte_count[73:64], zero pad
  input  logic [ftcs_pkg::IN_TDATA_W-1:0]    in_tdata,
  // func
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // chunk_flash_address[31:0], chunk_length[41:32], bounce_offset[43:42],
  // bytes_taken[53:44], chunk_buffer_address[85:54], zero pad
  output logic [ftcs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // via_bounce
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int unsigned AW  = ftcs_pkg::ADDR_W;
  localparam int unsigned NW  = ftcs_pkg::CNT_W;
  localparam int unsigned PW  = $clog2(PAGE_SIZE) + 1;
  localparam int unsigned CW  = ((PW > NW + 1) ? PW : NW + 1) + 1;
  localparam int unsigned CAP = (BOUNCE_BYTES / 4) * 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_SEND = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]                  fa_r, ba_r;
  logic [NW-1:0]                  left_r;
  logic                           wr_r, oor_r;
  logic [ftcs_pkg::RCNT_W-1:0]    cnt_r;

  logic [AW-1:0]                  o_fa_r, o_ba_r;
  logic [NW-1:0]                  o_len_r, o_taken_r;
  logic [ftcs_pkg::BOFF_W-1:0]    o_boff_r;
  logic                           o_bounce_r, o_last_r;

  // request decode
  logic [AW-1:0] req_fa, req_ba;
  logic [NW-1:0] req_cnt, req_n;
  logic          in_hs, out_hs;

  assign req_fa  = in_tdata[ftcs_pkg::IN_FA_LSB +: AW];
  assign req_ba  = in_tdata[ftcs_pkg::IN_BA_LSB +: AW];
  assign req_cnt = in_tdata[ftcs_pkg::IN_CNT_LSB +: NW];
  assign req_n   = (ftcs_pkg::MAXCMP_W'(req_cnt) > ftcs_pkg::MAXCMP_W'(MAX_REQUEST_BYTES))
                   ? NW'(MAX_REQUEST_BYTES) : req_cnt;

  assign in_tready = (state_r == ST_IDLE);
  assign in_hs     = in_tvalid && in_tready;
  assign out_hs    = out_tvalid && out_tready;

  // shared chunk calculator
  logic [1:0]    off;
  logic [CW-1:0] rem, left_w, len_raw, len_cap, tk_b, tk_bm, tk_d, taken, len;
  logic          crosses, bounce;

  always_comb begin
    off     = fa_r[1:0];
    rem     = CW'(PAGE_SIZE) - CW'(fa_r[PW-2:0]);
    left_w  = CW'(left_r);
    crosses = wr_r && (left_w > rem);
    bounce  = (off != 2'd0) || (ba_r[1:0] != 2'd0) || (left_r < NW'(4)) ||
              (wr_r && oor_r);
    len_raw = crosses ? ((rem + CW'(3)) & ~CW'(3))
                      : ((left_w + CW'(off) + CW'(3)) & ~CW'(3));
    len_cap = (len_raw > CW'(CAP)) ? CW'(CAP) : len_raw;
    tk_b    = len_cap - CW'(off);
    tk_bm   = (tk_b > left_w) ? left_w : tk_b;
    tk_d    = crosses ? rem : (left_w & ~CW'(3));
    taken   = bounce ? tk_bm : tk_d;
    len     = bounce ? len_cap : tk_d;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_hs && (req_n != '0)) state_nxt = ST_CALC;
      end
      ST_CALC: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_hs) begin
          if (o_last_r || (cnt_r == ftcs_pkg::RCNT_W'(ftcs_pkg::RESULT_LIMIT - 1)))
            state_nxt = ST_IDLE;
          else
            state_nxt = ST_CALC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_hs)
        cnt_r <= '0;
      else if (out_hs)
        cnt_r <= cnt_r + ftcs_pkg::RCNT_W'(1);
    end
  end

  // working state: loaded on request, advanced when a descriptor is taken
  always_ff @(posedge clk) begin
    if (in_hs) begin
      fa_r   <= req_fa;
      ba_r   <= req_ba;
      left_r <= req_n;
      wr_r   <= in_tuser;
      oor_r  <= (req_ba & ftcs_pkg::RAM_MASK) != ftcs_pkg::RAM_BASE;
    end else if (out_hs) begin
      fa_r   <= fa_r + AW'(o_taken_r);
      ba_r   <= ba_r + AW'(o_taken_r);
      left_r <= left_r - o_taken_r;
    end
  end

  // descriptor register
  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      o_fa_r     <= bounce ? {fa_r[AW-1:2], 2'b00} : fa_r;
      o_ba_r     <= ba_r;
      o_len_r    <= len[NW-1:0];
      o_taken_r  <= taken[NW-1:0];
      o_boff_r   <= bounce ? off : 2'd0;
      o_bounce_r <= bounce;
      o_last_r   <= (taken == left_w);
    end
  end

  assign out_tvalid = (state_r == ST_SEND);
  assign out_tuser  = o_bounce_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {
    {(ftcs_pkg::OUT_TDATA_W - ftcs_pkg::OUT_USED_W){1'b0}},
    o_ba_r, o_taken_r, o_boff_r, o_len_r, o_fa_r
  };

endmodule

// ===== rtl/ftcs_checker.sv =====
// ----------------------------------------------------------------------------
// ftcs_checker
// Port-level checks for the flash transfer chunk splitter, bound to the top.
// ----------------------------------------------------------------------------
module ftcs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ftcs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  // a held descriptor does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("descriptor changed while stalled");

  // no new request is taken while descriptors are pending
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while busy");

  // DMA length is always whole words
  a_len_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ftcs_pkg::OUT_LEN_LSB +: 2] == 2'b00)
    else $error("chunk length not word multiple");

  // direct chunks start aligned with zero bounce offset
  a_direct: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[ftcs_pkg::OUT_BOFF_LSB +: 2] == 2'b00 &&
      out_tdata[ftcs_pkg::OUT_FA_LSB +: 2] == 2'b00)
    else $error("direct chunk misaligned");

  // no descriptor appears in the cycle after a request is taken
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("descriptor appeared too early");

endmodule

bind flash_transfer_chunk_splitter_top ftcs_checker u_ftcs_checker (.*);
